// ----- rtl/t2u128_pkg.sv -----
// shared types and constants for the text to 128-bit number parser
// no dependencies; imported by text_to_u128_parser_core
`default_nettype none

package t2u128_pkg;

    // conversion phase of the current string
    typedef enum logic [2:0] {
        PH_START     = 3'd0,
        PH_ZERO_SEEN = 3'd1,
        PH_RUN10     = 3'd2,
        PH_RUN16     = 3'd3,
        PH_STOPPED   = 3'd4
    } phase_t;

    // base select register codes
    typedef logic [1:0] base_sel_t;
    localparam base_sel_t BASE_AUTO = 2'd0;
    localparam base_sel_t BASE_DEC  = 2'd1;
    localparam base_sel_t BASE_HEX  = 2'd2;

    // widths
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned ACC_W   = 128;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned PROD_W  = ACC_W + 4;
    localparam int unsigned M_DATA_W = 136;

    // character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

endpackage

`default_nettype wire

// ----- rtl/text_to_u128_parser_core.sv -----
// text to 128-bit unsigned number parser: decimal, hex or auto 0x prefix
// a last character passes the input and result registers; shift-and-add in one stage
// throughput: one character per cycle, stalled while a last character waits on a held result
// reset: aresetn synchronous active low, clears pipeline valids, phase,
// accumulator, overflow flag and base select (auto)
// depends on t2u128_pkg
`default_nettype none

module text_to_u128_parser_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // base select write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire t2u128_pkg::base_sel_t         cfg_data,
    // character stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] char_code
    input  wire logic                          s_tlast,   // last_char
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [t2u128_pkg::M_DATA_W-1:0]    m_tdata    // [63:0] value_low,
                                                          // [127:64] value_high,
                                                          // [128] status, rest zero
);
    import t2u128_pkg::*;

    // configuration
    base_sel_t             base_sel_reg;

    // input stage
    logic                  in_valid_reg;
    logic [CHAR_W-1:0]     in_char_reg;
    logic                  in_last_reg;

    // conversion state
    phase_t                phase_reg, phase_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic                  ovf_reg, ovf_next;

    // output stage
    logic                  out_valid_reg;
    logic [ACC_W-1:0]      out_value_reg;
    logic                  out_status_reg;

    // decode and datapath
    logic                  adv;
    logic                  run_en;
    logic                  use_hex;
    logic                  is_blank;
    logic                  is_dec;
    logic                  is_hex_letter;
    logic                  digit_ok;
    logic [3:0]            digit;
    logic [PROD_W-1:0]     prod;
    logic                  carry;
    logic                  take_digit;

    // handshakes
    assign cfg_ready = 1'b1;
    assign adv       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || adv;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, out_status_reg, out_value_reg};

    // base select register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_sel_reg <= BASE_AUTO;
        end else if (cfg_valid && cfg_ready) begin
            base_sel_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // character classes
    assign is_blank      = (in_char_reg == CH_SPACE) ||
                           ((in_char_reg >= CH_TAB) && (in_char_reg <= CH_CR));
    assign is_dec        = (in_char_reg >= CH_ZERO) && (in_char_reg <= CH_NINE);
    assign is_hex_letter = ((in_char_reg >= CH_LO_A) && (in_char_reg <= CH_LO_F)) ||
                           ((in_char_reg >= CH_UP_A) && (in_char_reg <= CH_UP_F));
    assign digit         = is_dec ? in_char_reg[3:0] : in_char_reg[3:0] + 4'd9;
    assign digit_ok      = is_dec || (use_hex && is_hex_letter);

    // phase decode: does this character go through the digit path, and in which base
    always_comb begin
        run_en  = 1'b0;
        use_hex = 1'b0;
        case (phase_reg)
            PH_START: begin
                if (base_sel_reg == BASE_DEC) begin
                    run_en = 1'b1;
                end else if (base_sel_reg == BASE_HEX) begin
                    run_en  = 1'b1;
                    use_hex = 1'b1;
                end else if (!is_blank && (in_char_reg != CH_ZERO)) begin
                    run_en = 1'b1;
                end
            end
            PH_ZERO_SEEN: begin
                run_en = (in_char_reg != CH_LO_X) && (in_char_reg != CH_UP_X);
            end
            PH_RUN10: begin
                run_en = 1'b1;
            end
            PH_RUN16: begin
                run_en  = 1'b1;
                use_hex = 1'b1;
            end
            default: begin
                run_en = 1'b0;
            end
        endcase
    end

    // multiply by base and add digit, shift-and-add
    always_comb begin
        if (use_hex) begin
            prod = {acc_reg, 4'd0} + {{(PROD_W-4){1'b0}}, digit};
        end else begin
            prod = {1'b0, acc_reg, 3'd0} + {3'd0, acc_reg, 1'b0} +
                   {{(PROD_W-4){1'b0}}, digit};
        end
    end

    assign carry      = |prod[PROD_W-1:ACC_W];
    assign take_digit = run_en && !is_blank && digit_ok;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_START: begin
                if (base_sel_reg == BASE_DEC) begin
                    phase_next = PH_RUN10;
                end else if (base_sel_reg == BASE_HEX) begin
                    phase_next = PH_RUN16;
                end else if (is_blank) begin
                    phase_next = PH_START;
                end else if (in_char_reg == CH_ZERO) begin
                    phase_next = PH_ZERO_SEEN;
                end else begin
                    phase_next = PH_RUN10;
                end
            end
            PH_ZERO_SEEN: begin
                phase_next = run_en ? PH_RUN10 : PH_RUN16;
            end
            PH_RUN10: begin
                phase_next = PH_RUN10;
            end
            PH_RUN16: begin
                phase_next = PH_RUN16;
            end
            default: begin
                phase_next = PH_STOPPED;
            end
        endcase
        // a non-digit or a carry out ends conversion
        if (run_en && !is_blank && (!digit_ok || carry)) begin
            phase_next = PH_STOPPED;
        end
        if (in_last_reg) begin
            phase_next = PH_START;
        end
    end

    // accumulator and overflow update
    always_comb begin
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        if (take_digit) begin
            acc_next = prod[ACC_W-1:0];
            ovf_next = ovf_reg || carry;
        end
    end

    // conversion state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (adv) begin
            phase_reg <= phase_next;
            acc_reg   <= in_last_reg ? '0 : acc_next;
            ovf_reg   <= in_last_reg ? 1'b0 : ovf_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_last_reg) begin
            out_value_reg  <= acc_next;
            out_status_reg <= ovf_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a new result only follows a last character leaving the input stage
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_last_reg))
        else $error("result without a last character");

    // state is back at start after a string ends
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_last_reg) |=> (phase_reg == PH_START) && (acc_reg == '0) && !ovf_reg)
        else $error("state not cleared after last character");

    // overflow always ends conversion
    a_ovf_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (phase_reg == PH_STOPPED))
        else $error("overflow without stopped phase");

    // a held character is never dropped
    a_in_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !adv) |=> in_valid_reg)
        else $error("stalled character lost");
`endif

endmodule

`default_nettype wire

// ----- bench/text_to_u128_parser_core_test.sv -----
// testbench for text_to_u128_parser_core: drives strings of characters, predicts the
// parsed 128-bit value and overflow status, and checks every result in order
// depends on t2u128_pkg and text_to_u128_parser_core
module text_to_u128_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import t2u128_pkg::*;

    // decimal text of the largest 128-bit value
    localparam string U128_MAX_DEC = "340282366920938463463374607431768211455";

    typedef struct {
        logic [HALF_W-1:0] value_low;
        logic [HALF_W-1:0] value_high;
        logic              status;
    } parsed_number_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    base_sel_t           cfg_data  = BASE_AUTO;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = 8'h00;   // [7:0] char_code
    logic                s_tlast   = 1'b0;    // last_char
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;             // [63:0] value_low, [127:64] value_high,
                                              // [128] status, rest zero

    // predictor state
    logic [ACC_W-1:0] acc_model   = '0;
    phase_t           parse_phase = PH_START;
    logic             ovf_model   = 1'b0;
    base_sel_t        base_now    = BASE_AUTO;

    parsed_number_t expected_numbers[$];

    int errors       = 0;
    int sent_chars   = 0;
    int checked_nums = 0;
    int ovf_seen     = 0;

    // sender burst control
    int burst_left = 0;
    bit gaps_on    = 1'b0;

    // receiver stall control
    int ready_mode = 0;
    int hold_req   = 0;
    int hold_left  = 0;
    int stall_tick = 0;

    text_to_u128_parser_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // run limit
    initial begin
        #2ms;
        $display("timeout at %0t with %0d results outstanding", $time, expected_numbers.size());
        $display("FAILURE");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // digit value, 16 when c is no digit of the base
    function automatic int digit_value(logic [7:0] c, bit hex);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (hex && c >= CH_LO_A && c <= CH_LO_F)
            return int'(c - CH_LO_A) + 10;
        if (hex && c >= CH_UP_A && c <= CH_UP_F)
            return int'(c - CH_UP_A) + 10;
        return 16;
    endfunction

    // one character in a running phase
    function automatic void accumulate_char(logic [7:0] c, bit hex);
        int               d;
        logic [PROD_W-1:0] radix;
        logic [PROD_W-1:0] prod;
        radix = hex ? PROD_W'(16) : PROD_W'(10);
        if (is_space(c))
            return;
        d = digit_value(c, hex);
        if (d >= int'(radix)) begin
            parse_phase = PH_STOPPED;
            return;
        end
        prod = {4'd0, acc_model} * radix + PROD_W'(d);
        acc_model = prod[ACC_W-1:0];
        if (prod[PROD_W-1:ACC_W] != '0) begin
            ovf_model   = 1'b1;
            parse_phase = PH_STOPPED;
        end
    endfunction

    function automatic void predict_char(logic [7:0] c, logic last);
        parsed_number_t num;
        case (parse_phase)
            PH_START: begin
                if (base_now == BASE_DEC) begin
                    parse_phase = PH_RUN10;
                    accumulate_char(c, 1'b0);
                end else if (base_now == BASE_HEX) begin
                    parse_phase = PH_RUN16;
                    accumulate_char(c, 1'b1);
                end else if (is_space(c)) begin
                    // still waiting for the first non-blank
                end else if (c == CH_ZERO) begin
                    parse_phase = PH_ZERO_SEEN;
                end else begin
                    parse_phase = PH_RUN10;
                    accumulate_char(c, 1'b0);
                end
            end
            PH_ZERO_SEEN: begin
                if (c == CH_LO_X || c == CH_UP_X) begin
                    parse_phase = PH_RUN16;
                end else begin
                    // the leading zero was a plain decimal digit
                    parse_phase = PH_RUN10;
                    accumulate_char(c, 1'b0);
                end
            end
            PH_RUN10: accumulate_char(c, 1'b0);
            PH_RUN16: accumulate_char(c, 1'b1);
            default:  parse_phase = PH_STOPPED;
        endcase
        if (last) begin
            num.value_low  = acc_model[HALF_W-1:0];
            num.value_high = acc_model[ACC_W-1:HALF_W];
            num.status     = ovf_model;
            expected_numbers.push_back(num);
            acc_model   = '0;
            parse_phase = PH_START;
            ovf_model   = 1'b0;
        end
    endfunction

    // ---------------- result checker ----------------

    always @(posedge aclk) begin
        parsed_number_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_numbers.size() == 0) begin
                $display("%0t: unexpected result, got %h", $time, m_tdata);
                errors++;
            end else begin
                want = expected_numbers.pop_front();
                checked_nums++;
                if (want.status)
                    ovf_seen++;
                if (m_tdata[63:0] !== want.value_low) begin
                    $display("%0t: value_low mismatch, expected %h, got %h",
                             $time, want.value_low, m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[127:64] !== want.value_high) begin
                    $display("%0t: value_high mismatch, expected %h, got %h",
                             $time, want.value_high, m_tdata[127:64]);
                    errors++;
                end
                if (m_tdata[128] !== want.status) begin
                    $display("%0t: status mismatch, expected %b, got %b",
                             $time, want.status, m_tdata[128]);
                    errors++;
                end
                if (m_tdata[M_DATA_W-1:129] !== '0) begin
                    $display("%0t: pad bits mismatch, expected 0, got %h",
                             $time, m_tdata[M_DATA_W-1:129]);
                    errors++;
                end
            end
        end
    end

    // ---------------- receiver stalls ----------------

    always @(negedge aclk) begin
        stall_tick++;
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ((stall_tick % 7) < 4);
            endcase
        end
    end

    // ---------------- driving ----------------

    // offer one character, with bursts and gaps on the sender side
    task automatic send_char(logic [7:0] c, logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_char(c, last);
        sent_chars++;
        burst_left--;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_bytes(logic [7:0] chars[$]);
        for (int i = 0; i < chars.size(); i++)
            send_char(chars[i], i == chars.size() - 1);
    endtask

    // stop offering, wait for every outstanding number, then idle before returning
    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_numbers.size() != 0 && waited < 50000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_base(base_sel_t sel);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= sel;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        base_now = sel;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------- random strings ----------------

    function automatic logic [7:0] rand_digit(bit hex);
        int d;
        d = hex ? $urandom_range(0, 15) : $urandom_range(0, 9);
        if (d < 10)
            return CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(d - 10);
    endfunction

    function automatic logic [7:0] rand_blank();
        int v;
        v = $urandom_range(8, 13);
        return (v == 8) ? CH_SPACE : 8'(v);
    endfunction

    // number text suited to the current base setting, with random content
    task automatic send_random_string();
        logic [7:0] chars[$];
        bit         hex;
        int         kind;
        int         n;
        bit         auto_mode;
        auto_mode = (base_now != BASE_DEC && base_now != BASE_HEX);
        hex  = (base_now == BASE_HEX) || (auto_mode && $urandom_range(0, 1));
        kind = $urandom_range(0, 9);
        if (kind <= 7 && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) chars.push_back(rand_blank());
        end
        if (kind <= 7 && hex && (auto_mode || $urandom_range(0, 7) == 0)) begin
            chars.push_back(CH_ZERO);
            chars.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
        end
        if (kind <= 5) begin
            // ordinary number, mostly short
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 34) : $urandom_range(1, 8);
            repeat (n) begin
                chars.push_back(rand_digit(hex));
                if ($urandom_range(0, 9) == 0)
                    chars.push_back(rand_blank());
            end
            if ($urandom_range(0, 3) == 0) begin
                chars.push_back(8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 3)) chars.push_back(rand_digit(hex));
            end
        end else if (kind <= 7) begin
            // at or just past the 128-bit limit
            if (hex) begin
                n = 32 + $urandom_range(0, 1);
                repeat (n) chars.push_back(($urandom_range(0, 2) != 0) ? CH_LO_F : rand_digit(1));
            end else begin
                for (int i = 0; i < U128_MAX_DEC.len(); i++)
                    chars.push_back(U128_MAX_DEC[i]);
                case ($urandom_range(0, 2))
                    0: ;
                    1: chars[chars.size() - 1] = CH_ZERO + 8'($urandom_range(6, 9));
                    default: chars.push_back(rand_digit(0));
                endcase
            end
        end else if (kind == 8) begin
            // raw noise over the whole code range
            repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
        end else begin
            // leading zero and whatever follows
            chars.push_back(CH_ZERO);
            if ($urandom_range(0, 3) != 0)
                chars.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 4)) chars.push_back(rand_digit($urandom_range(0, 1)));
        end
        send_bytes(chars);
    endtask

    task automatic run_random_phase(base_sel_t sel, int budget, int rmode, bit gaps);
        int stop_at;
        write_base(sel);
        ready_mode = rmode;
        gaps_on    = gaps;
        stop_at    = sent_chars + budget;
        while (sent_chars < stop_at)
            send_random_string();
    endtask

    // ---------------- tests ----------------

    task automatic test_auto_detect();
        ready_mode = 1;
        gaps_on    = 1'b1;
        send_text("0");          // lone zero at the end
        send_text("0x1F");
        send_text(" \t0Xa");
        send_text("0 5");        // lone zero then a blank
        send_text("12z9");       // stop on a non-digit
        send_char(8'hFF, 1'b1);  // high code only
        send_char(8'h00, 1'b0);
        send_text("7");
    endtask

    task automatic test_forced_decimal();
        write_base(BASE_DEC);
        send_text("\r42");
        send_text("9a");
    endtask

    task automatic test_forced_hex();
        write_base(BASE_HEX);
        send_text("0x5");        // prefix is not stripped
        send_text("aF");
    endtask

    task automatic test_unused_selector();
        write_base(base_sel_t'(3));
        send_text("0X9");
    endtask

    task automatic test_random_mix();
        run_random_phase(BASE_AUTO, 120, 0, 1'b0);
        run_random_phase(BASE_DEC, 110, 1, 1'b1);
        run_random_phase(BASE_HEX, 110, 2, 1'b1);
        run_random_phase(base_sel_t'(3), 100, 1, 1'b0);
        run_random_phase(BASE_AUTO, 110, 2, 1'b1);
        run_random_phase(BASE_HEX, 80, 1, 1'b1);
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        int stop_at;
        write_base(BASE_AUTO);
        gaps_on    = 1'b0;
        ready_mode = 1;
        hold_req   = 200;
        stop_at    = sent_chars + 60;
        while (sent_chars < stop_at)
            send_random_string();
        drain_results();
        // sender resumes only after everything has come back
        stop_at = sent_chars + 20;
        while (sent_chars < stop_at)
            send_random_string();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_auto_detect();
        test_forced_decimal();
        test_forced_hex();
        test_unused_selector();
        test_random_mix();
        test_backpressure();

        drain_results();
        if (expected_numbers.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_numbers.size());
            errors++;
        end
        $display("sent %0d characters, checked %0d numbers (%0d overflowed), %0d errors",
                 sent_chars, checked_nums, ovf_seen, errors);
        $display("bases auto, decimal, hex and the spare code; stalls, bursts and a long hold-off");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/t2u128_pkg.sv
rtl/text_to_u128_parser_core.sv
bench/text_to_u128_parser_core_test.sv
